FILE: rtl/core/grmmc_pkg.sv
// ----------------------------------------------------------------------------
// grmmc_pkg - shared types and constants of the region merge maze carver
// Grid sizes, field widths, request and control codes, column control and
// column read-back structs, and the size clamp helper.
// ----------------------------------------------------------------------------
package grmmc_pkg;

  // grid capacity
  localparam int MAX_COLS = 16;
  localparam int MAX_ROWS = 16;
  localparam int MAX_DIM  = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;

  // derived widths
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int SIZE_W = $clog2(MAX_DIM + 1);
  localparam int LBL_W  = $clog2(MAX_COLS * MAX_ROWS + 1);

  // fixed field widths
  localparam int REQ_W     = 2;
  localparam int DIR_W     = 2;
  localparam int WALL_W    = 4;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;
  localparam logic [CFG_W-1:0]     GRID_WIDTH_RST  = 5'd16;
  localparam logic [CFG_W-1:0]     GRID_HEIGHT_RST = 5'd16;

  // request types (code 3 behaves as a read)
  localparam logic [REQ_W-1:0] REQ_CONNECT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd2;

  // neighbor directions
  localparam logic [DIR_W-1:0] DIR_NORTH = 2'd0;
  localparam logic [DIR_W-1:0] DIR_EAST  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_SOUTH = 2'd2;
  localparam logic [DIR_W-1:0] DIR_WEST  = 2'd3;

  // passage bits of a cell: east toward x+1, south toward y+1
  localparam logic [1:0] PASS_E = 2'b01;
  localparam logic [1:0] PASS_S = 2'b10;

  // column operation codes
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_MERGE = 2'd2;

  // control broadcast to every column
  typedef struct packed {
    logic [ROW_W-1:0]  rd_row;
    logic [1:0]        op;
    logic [LBL_W-1:0]  from_lbl;
    logic [LBL_W-1:0]  to_lbl;
    logic [COL_W-1:0]  pass_col;
    logic [ROW_W-1:0]  pass_row;
    logic [1:0]        pass_mask;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
  } col_ctl_t;

  // read-back from one column
  typedef struct packed {
    logic [LBL_W-1:0] lbl;
    logic [1:0]       pass;
    logic [1:0]       west_pass;
    logic [LBL_W-1:0] head_lbl;
  } col_rd_t;

  // clamp a size register to 1..maxv
  function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] v, input int maxv);
    logic [SIZE_W-1:0] res;
    if (v == '0) begin
      res = SIZE_W'(1);
    end else if (int'(v) > maxv) begin
      res = SIZE_W'(maxv);
    end else begin
      res = SIZE_W'(v);
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/grmmc_req_if.sv
// ----------------------------------------------------------------------------
// grmmc_req_if - request channel of the maze carver
// Valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
interface grmmc_req_if;
  logic                          valid;
  logic                          ready;
  logic [grmmc_pkg::REQ_W-1:0]   req_type;
  logic [grmmc_pkg::COL_W-1:0]   cell_x;
  logic [grmmc_pkg::ROW_W-1:0]   cell_y;
  logic [grmmc_pkg::DIR_W-1:0]   direction;

  modport source (output valid, req_type, cell_x, cell_y, direction, input ready);
  modport sink (input valid, req_type, cell_x, cell_y, direction, output ready);
endinterface

FILE: rtl/core/grmmc_rsp_if.sv
// ----------------------------------------------------------------------------
// grmmc_rsp_if - result channel of the maze carver
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface grmmc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic                          merged;
  logic [grmmc_pkg::WALL_W-1:0]  wall_bits;
  logic [grmmc_pkg::LBL_W-1:0]   region_label;
  logic                          all_joined;

  modport source (output valid, status, merged, wall_bits, region_label, all_joined,
                  input ready);
  modport sink (input valid, status, merged, wall_bits, region_label, all_joined,
                output ready);
endinterface

FILE: rtl/core/grmmc_column.sv
// ----------------------------------------------------------------------------
// grmmc_column - one grid column of the maze carver
// Holds the labels and passage bits of all rows of one column, applies the
// broadcast clear / relabel / passage update, reads one row per cycle and
// hands its passage bits and the running all-equal flag to the next column.
// ----------------------------------------------------------------------------
module grmmc_column (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [grmmc_pkg::COL_W-1:0]    col_idx,
  input  grmmc_pkg::col_ctl_t            ctl,
  input  logic [1:0]                     west_pass,
  output logic [1:0]                     east_pass,
  input  logic                           all_in,
  output logic                           all_out,
  input  logic [grmmc_pkg::LBL_W-1:0]    head_lbl,
  output grmmc_pkg::col_rd_t             rd
);

  logic [grmmc_pkg::LBL_W-1:0] lbl_r  [grmmc_pkg::MAX_ROWS];
  logic [1:0]                  pass_r [grmmc_pkg::MAX_ROWS];

  logic [grmmc_pkg::LBL_W-1:0]    base_run;
  logic [grmmc_pkg::LBL_W-1:0]    base_rst;
  logic                           col_used;
  logic                           row_used [grmmc_pkg::MAX_ROWS];
  logic [grmmc_pkg::MAX_ROWS-1:0] row_match;

  // first label of this column: col * height + 1
  assign base_run = grmmc_pkg::LBL_W'(col_idx) * grmmc_pkg::LBL_W'(ctl.h);
  assign base_rst = grmmc_pkg::LBL_W'(col_idx) * grmmc_pkg::LBL_W'(grmmc_pkg::MAX_ROWS);
  assign col_used = grmmc_pkg::SIZE_W'(col_idx) < ctl.w;

  // rows in use and match against the head cell
  always_comb begin
    for (int r = 0; r < grmmc_pkg::MAX_ROWS; r++) begin
      row_used[r]  = grmmc_pkg::SIZE_W'(r) < ctl.h;
      row_match[r] = !row_used[r] || (lbl_r[r] == head_lbl);
    end
  end

  assign all_out = all_in && (!col_used || (&row_match));

  // row read-back and handoff to the east neighbor
  assign rd.lbl       = lbl_r[ctl.rd_row];
  assign rd.pass      = pass_r[ctl.rd_row];
  assign rd.west_pass = west_pass;
  assign rd.head_lbl  = lbl_r[0];
  assign east_pass    = pass_r[ctl.rd_row];

  // label and passage storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < grmmc_pkg::MAX_ROWS; r++) begin
        lbl_r[r]  <= base_rst + grmmc_pkg::LBL_W'(r) + grmmc_pkg::LBL_W'(1);
        pass_r[r] <= 2'b00;
      end
    end else begin
      case (ctl.op)
        grmmc_pkg::OP_CLEAR: begin
          for (int r = 0; r < grmmc_pkg::MAX_ROWS; r++) begin
            lbl_r[r]  <= base_run + grmmc_pkg::LBL_W'(r) + grmmc_pkg::LBL_W'(1);
            pass_r[r] <= 2'b00;
          end
        end
        grmmc_pkg::OP_MERGE: begin
          for (int r = 0; r < grmmc_pkg::MAX_ROWS; r++) begin
            if (col_used && row_used[r] && (lbl_r[r] == ctl.from_lbl)) begin
              lbl_r[r] <= ctl.to_lbl;
            end
            if ((ctl.pass_col == col_idx) && (ctl.pass_row == grmmc_pkg::ROW_W'(r))) begin
              pass_r[r] <= pass_r[r] | ctl.pass_mask;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/grid_region_merge_maze_carver.sv
// ----------------------------------------------------------------------------
// grid_region_merge_maze_carver - region merging maze carver
// Keeps a grid of region labels and passages; connect, read and clear
// requests each return one result word.
// ----------------------------------------------------------------------------
// Usage:
//   in_req   request words (req_type, cell_x, cell_y, direction), valid/ready
//   out_rsp  result words (status, merged, wall_bits, region_label,
//            all_joined), valid/ready, held in an output register
//   cfg_*    write port for grid_width (index 0) and grid_height (index 1);
//            write only while no request is in flight
// Sequencing:
//   a request goes through a five-step sequencer (read own cell, read
//   neighbor, broadcast update, read back with all-joined scan, read north
//   passage). The result goes to the output register after the last step,
//   and a new request is taken only once the sequencer is idle again; the
//   sequencer is set by the one row per cycle read port of each column.
//   Relabelling is a single broadcast compare and replace over all columns.
// Reset: synchronous, active low; sizes return to 16x16, every cell gets its
//   own label col*16+row+1 and all passages close, in the same cycle.
// Stall: while out_rsp.ready is low the result holds; one more request may be
//   accepted and waits in its last step until the output register frees.
// ----------------------------------------------------------------------------
module grid_region_merge_maze_carver (
  input  logic                              clk,
  input  logic                              rst_n,
  grmmc_req_if.sink                         in_req,
  grmmc_rsp_if.source                       out_rsp,
  input  logic                              cfg_we,
  input  logic [grmmc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [grmmc_pkg::CFG_W-1:0]       cfg_wdata
);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_HERE  = 3'd1;
  localparam logic [2:0] ST_THERE = 3'd2;
  localparam logic [2:0] ST_APPLY = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_NORTH = 3'd5;

  logic [2:0] state_r, state_nxt;

  logic [grmmc_pkg::CFG_W-1:0]  grid_width_r, grid_height_r;
  logic [grmmc_pkg::SIZE_W-1:0] w_eff, h_eff;

  // latched request
  logic [grmmc_pkg::REQ_W-1:0] req_r;
  logic [grmmc_pkg::COL_W-1:0] x_r, nx_r;
  logic [grmmc_pkg::ROW_W-1:0] y_r, ny_r;
  logic [grmmc_pkg::DIR_W-1:0] dir_r;
  logic                        inside_r, nb_ok_r;

  // captured reads
  logic [grmmc_pkg::LBL_W-1:0] here_r, there_r, lbl_rd_r;
  logic [1:0]                  pass_xy_r, west_r;
  logic                        joined_r, merged_r;

  // output register
  logic                         out_valid_r;
  logic                         out_status_r, out_merged_r, out_joined_r;
  logic [grmmc_pkg::WALL_W-1:0] out_walls_r;
  logic [grmmc_pkg::LBL_W-1:0]  out_lbl_r;

  // accept-time decode
  logic                        in_fire, in_grid, nb_ok;
  logic [grmmc_pkg::COL_W-1:0] nx;
  logic [grmmc_pkg::ROW_W-1:0] ny;

  // column control and read-back
  grmmc_pkg::col_ctl_t         ctl;
  logic [grmmc_pkg::COL_W-1:0] col_sel;
  grmmc_pkg::col_rd_t          rd_w    [grmmc_pkg::MAX_COLS];
  grmmc_pkg::col_rd_t          rd_sel;
  logic [1:0]                  east_w  [grmmc_pkg::MAX_COLS];
  logic [1:0]                  west_w  [grmmc_pkg::MAX_COLS];
  logic                        all_w   [grmmc_pkg::MAX_COLS + 1];

  logic                         merge_ok, slot_free;
  logic [grmmc_pkg::WALL_W-1:0] walls;

  assign w_eff = grmmc_pkg::eff_size(grid_width_r, grmmc_pkg::MAX_COLS);
  assign h_eff = grmmc_pkg::eff_size(grid_height_r, grmmc_pkg::MAX_ROWS);

  assign in_req.ready = (state_r == ST_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;
  assign slot_free    = !out_valid_r || out_rsp.ready;

  // cell range and neighbor of the incoming request
  always_comb begin
    in_grid = (grmmc_pkg::SIZE_W'(in_req.cell_x) < w_eff) &&
              (grmmc_pkg::SIZE_W'(in_req.cell_y) < h_eff);
    nx = in_req.cell_x;
    ny = in_req.cell_y;
    case (in_req.direction)
      grmmc_pkg::DIR_NORTH: begin
        nb_ok = in_req.cell_y != '0;
        ny    = in_req.cell_y - grmmc_pkg::ROW_W'(1);
      end
      grmmc_pkg::DIR_EAST: begin
        nb_ok = (grmmc_pkg::SIZE_W'(in_req.cell_x) + grmmc_pkg::SIZE_W'(1)) < w_eff;
        nx    = in_req.cell_x + grmmc_pkg::COL_W'(1);
      end
      grmmc_pkg::DIR_SOUTH: begin
        nb_ok = (grmmc_pkg::SIZE_W'(in_req.cell_y) + grmmc_pkg::SIZE_W'(1)) < h_eff;
        ny    = in_req.cell_y + grmmc_pkg::ROW_W'(1);
      end
      default: begin
        nb_ok = in_req.cell_x != '0;
        nx    = in_req.cell_x - grmmc_pkg::COL_W'(1);
      end
    endcase
  end

  // a connect joins two regions only with distinct labels
  assign merge_ok = (req_r == grmmc_pkg::REQ_CONNECT) && inside_r && nb_ok_r &&
                    (here_r != there_r);

  // broadcast control per sequencer step
  always_comb begin
    ctl       = '0;
    ctl.w     = w_eff;
    ctl.h     = h_eff;
    ctl.op    = grmmc_pkg::OP_NONE;
    col_sel   = x_r;
    case (state_r)
      ST_HERE: begin
        ctl.rd_row = y_r;
      end
      ST_THERE: begin
        ctl.rd_row = ny_r;
        col_sel    = nx_r;
      end
      ST_APPLY: begin
        if (req_r == grmmc_pkg::REQ_CLEAR) begin
          ctl.op = grmmc_pkg::OP_CLEAR;
        end else if (merge_ok) begin
          ctl.op       = grmmc_pkg::OP_MERGE;
          ctl.from_lbl = (here_r > there_r) ? here_r : there_r;
          ctl.to_lbl   = (here_r > there_r) ? there_r : here_r;
          // north and west walls live in the neighbor cell
          if (dir_r == grmmc_pkg::DIR_NORTH || dir_r == grmmc_pkg::DIR_WEST) begin
            ctl.pass_col = nx_r;
            ctl.pass_row = ny_r;
          end else begin
            ctl.pass_col = x_r;
            ctl.pass_row = y_r;
          end
          ctl.pass_mask = (dir_r == grmmc_pkg::DIR_NORTH || dir_r == grmmc_pkg::DIR_SOUTH) ?
                          grmmc_pkg::PASS_S : grmmc_pkg::PASS_E;
        end
      end
      ST_READ: begin
        ctl.rd_row = y_r;
      end
      ST_NORTH: begin
        ctl.rd_row = y_r - grmmc_pkg::ROW_W'(1);
      end
      default: begin
      end
    endcase
  end

  // chain of columns
  assign all_w[0] = 1'b1;

  for (genvar c = 0; c < grmmc_pkg::MAX_COLS; c++) begin : g_col
    if (c == 0) begin : g_edge
      assign west_w[c] = 2'b00;
    end else begin : g_link
      assign west_w[c] = east_w[c-1];
    end

    grmmc_column u_col (
      .clk       (clk),
      .rst_n     (rst_n),
      .col_idx   (grmmc_pkg::COL_W'(c)),
      .ctl       (ctl),
      .west_pass (west_w[c]),
      .east_pass (east_w[c]),
      .all_in    (all_w[c]),
      .all_out   (all_w[c+1]),
      .head_lbl  (rd_w[0].head_lbl),
      .rd        (rd_w[c])
    );
  end

  assign rd_sel = rd_w[col_sel];

  // walls of the addressed cell after the update
  always_comb begin
    walls[0] = (y_r == '0) || !rd_sel.pass[1];
    walls[1] = ((grmmc_pkg::SIZE_W'(x_r) + grmmc_pkg::SIZE_W'(1)) >= w_eff) || !pass_xy_r[0];
    walls[2] = ((grmmc_pkg::SIZE_W'(y_r) + grmmc_pkg::SIZE_W'(1)) >= h_eff) || !pass_xy_r[1];
    walls[3] = (x_r == '0) || !west_r[0];
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_HERE;
      ST_HERE:  state_nxt = ST_THERE;
      ST_THERE: state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_NORTH;
      ST_NORTH: if (slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      grid_width_r  <= grmmc_pkg::GRID_WIDTH_RST;
      grid_height_r <= grmmc_pkg::GRID_HEIGHT_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_NORTH && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_idx)
          grmmc_pkg::CFG_GRID_WIDTH:  grid_width_r  <= cfg_wdata;
          grmmc_pkg::CFG_GRID_HEIGHT: grid_height_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // request and read capture, result word
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r    <= in_req.req_type;
      x_r      <= in_req.cell_x;
      y_r      <= in_req.cell_y;
      dir_r    <= in_req.direction;
      nx_r     <= nx;
      ny_r     <= ny;
      inside_r <= in_grid;
      nb_ok_r  <= nb_ok;
    end
    case (state_r)
      ST_HERE:  here_r   <= rd_sel.lbl;
      ST_THERE: there_r  <= rd_sel.lbl;
      ST_APPLY: merged_r <= merge_ok;
      ST_READ: begin
        lbl_rd_r  <= rd_sel.lbl;
        pass_xy_r <= rd_sel.pass;
        west_r    <= rd_sel.west_pass;
        joined_r  <= all_w[grmmc_pkg::MAX_COLS];
      end
      ST_NORTH: begin
        if (slot_free) begin
          out_status_r <= !inside_r;
          out_merged_r <= merged_r;
          out_walls_r  <= inside_r ? walls : '0;
          out_lbl_r    <= inside_r ? lbl_rd_r : '0;
          out_joined_r <= joined_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = out_status_r;
  assign out_rsp.merged       = out_merged_r;
  assign out_rsp.wall_bits    = out_walls_r;
  assign out_rsp.region_label = out_lbl_r;
  assign out_rsp.all_joined   = out_joined_r;

  // checks
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_HERE))
    else $error("accepted word did not start the sequencer");

  a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NORTH && slot_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished word not loaded into output register");

  a_merge_order: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == grmmc_pkg::OP_MERGE) |-> (ctl.from_lbl > ctl.to_lbl && state_r == ST_APPLY))
    else $error("relabel broadcast with bad label order or outside update step");

  a_outside_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && out_rsp.status) |->
      (!out_rsp.merged && out_rsp.wall_bits == '0 && out_rsp.region_label == '0))
    else $error("out of grid result carries cell data");

endmodule
